@@ rtl/sgse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgse_pkg
// Types and constants shared by the segment grid sweep blocks.
// ----------------------------------------------------------------------------
package sgse_pkg;

  // stream payload widths
  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 3;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_LANE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OTHER_WEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_WEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_OFFSET    = 3'd4;

  // item kinds and cell kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [1:0] KIND_BLOCKED = 2'd0;
  localparam logic [1:0] KIND_PADDING = 2'd2;

  // result classes
  localparam logic [1:0] CLS_PLAIN   = 2'd0;
  localparam logic [1:0] CLS_OTHER   = 2'd1;
  localparam logic [1:0] CLS_PADDING = 2'd2;
  localparam logic [1:0] CLS_BLOCKED = 2'd3;

  // arithmetic widths
  localparam int unsigned CRD_W  = 14;  // signed cell coordinate / quotient
  localparam int unsigned DIVD_W = 16;  // magnitude of a coordinate delta
  localparam int unsigned MAG_W  = 25;  // |err| + offset
  localparam int unsigned WGT_W  = 16;
  localparam int unsigned PROD_W = MAG_W + WGT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_SWEEP,
    ST_DRAIN,
    ST_MUL,
    ST_OUT
  } state_e;

endpackage

@@ rtl/sgse_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgse_div
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module sgse_div
  import sgse_pkg::*;
#(
  parameter int unsigned DW = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DW-1:0]     divisor_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quot_o,
  output logic [DW-1:0]     rem_o
);

  localparam int unsigned CNT_W = $clog2(DIVD_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVD_W-1:0] quot_q, quot_d;
  logic [DW-1:0]     rem_q, rem_d;
  logic [DW-1:0]     div_q, div_d;
  logic [DW:0]       shifted;
  logic              fits;

  always_comb begin
    shifted = {rem_q, quot_q[DIVD_W-1]};
    fits    = shifted >= {1'b0, div_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? DW'(shifted - {1'b0, div_q}) : DW'(shifted);
      quot_d = {quot_q[DIVD_W-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/segment_grid_sweep_error_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_grid_sweep_error_top
// Grid map store plus segment sweep check with weighted lateral error.
// ----------------------------------------------------------------------------
// Channel     Dir  Handshake                     Carries
// s_axis      in   s_axis_tvalid/s_axis_tready   map write or segment check
// m_axis      out  m_axis_tvalid/m_axis_tready   one result per check
// cfg         in   cfg_valid_i/cfg_ready_o       register index + data
//
// Write request: written to the map on acceptance. Check request: the
// shared divider forms the x step, then the y step; the sweep then reads
// each sample through the single map read port; drain, multiply, output.
// Reset clears control and loads register defaults; map contents are
// undefined until written. A stalled output holds the finished result; a
// new request is taken as soon as the sequencer is back in idle.
// ----------------------------------------------------------------------------
module segment_grid_sweep_error_top
  import sgse_pkg::*;
#(
  parameter int unsigned GRID_WIDTH  = 256,
  parameter int unsigned GRID_HEIGHT = 256,
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // tdata: write_x[7:0], write_y[15:8], cell_kind[17:16], start_x[33:18],
  //        start_y[49:34], end_x[65:50], end_y[81:66], lateral_error[105:82]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: op[0]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: weighted_error[31:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: blocked[0], error_class[2:1]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned NW     = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned CW     = (NW > 7) ? NW : 7;
  localparam int unsigned DW     = NW + 4;
  localparam int unsigned CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned AW     = $clog2(CELLS);
  localparam int unsigned XW     = $clog2(GRID_WIDTH);
  localparam int unsigned YW     = $clog2(GRID_HEIGHT);

  // ---------------------------------------------------------------- fields
  logic [7:0]         in_wx, in_wy;
  logic [1:0]         in_kind;
  logic signed [15:0] in_sx, in_sy, in_ex, in_ey;
  logic signed [23:0] in_err;
  logic               in_op;

  assign in_wx   = s_axis_tdata[7:0];
  assign in_wy   = s_axis_tdata[15:8];
  assign in_kind = s_axis_tdata[17:16];
  assign in_sx   = s_axis_tdata[33:18];
  assign in_sy   = s_axis_tdata[49:34];
  assign in_ex   = s_axis_tdata[65:50];
  assign in_ey   = s_axis_tdata[81:66];
  assign in_err  = s_axis_tdata[105:82];
  assign in_op   = s_axis_tuser[0];

  // ---------------------------------------------------------------- config
  logic [6:0]  smp_cnt_q;
  logic [22:0] half_lane_q;
  logic [15:0] other_wgt_q;
  logic [15:0] pad_wgt_q;
  logic [22:0] pad_off_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_cnt_q   <= 7'd8;
      half_lane_q <= 23'd2560;
      other_wgt_q <= 16'd256;
      pad_wgt_q   <= 16'd256;
      pad_off_q   <= 23'd5120;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_COUNT: smp_cnt_q   <= cfg_data_i[6:0];
        CFG_HALF_LANE:    half_lane_q <= cfg_data_i;
        CFG_OTHER_WEIGHT: other_wgt_q <= cfg_data_i[15:0];
        CFG_PAD_WEIGHT:   pad_wgt_q   <= cfg_data_i[15:0];
        CFG_PAD_OFFSET:   pad_off_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- registers
  state_e state_q, state_d;

  logic signed [16:0]      dx_q, dx_d, dy_q, dy_d;
  logic signed [23:0]      err_q, err_d;
  logic [NW-1:0]           nm1_q, nm1_d;
  logic [NW-1:0]           idx_q, idx_d;
  logic [DW-1:0]           den_q, den_d;
  logic signed [CRD_W-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [DW-1:0]           rx_q, rx_d, ry_q, ry_d;
  logic signed [CRD_W-1:0] qdx_q, qdx_d, qdy_q, qdy_d;
  logic [DW-1:0]           rdx_q, rdx_d, rdy_q, rdy_d;
  logic                    blk_q, blk_d, pad_q, pad_d;
  logic                    rd_pend_q, rd_pend_d;
  logic [1:0]              cls_q, cls_d;
  logic                    neg_q, neg_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic [OUT_TDATA_W-1:0]  out_data_q, out_data_d;
  logic [OUT_TUSER_W-1:0]  out_user_q, out_user_d;
  logic                    out_vld_q, out_vld_d;

  // ---------------------------------------------------------- map memory
  logic [1:0]    grid_mem [CELLS];
  logic [1:0]    rd_data_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= in_kind;
    end
    rd_data_q <= grid_mem[mem_raddr];
  end

  // -------------------------------------------------------------- divider
  logic              div_start, div_done;
  logic [DIVD_W-1:0] div_dividend, div_quot;
  logic [DW-1:0]     div_divisor, div_rem;

  sgse_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // ------------------------------------------------------ combinational
  logic                    in_accept;
  logic [CW-1:0]           cnt_ext;
  logic [NW-1:0]           n_sel;
  logic signed [16:0]      dx_in, dy_in;
  logic signed [16:0]      mag_src;
  logic                    adj_neg;
  logic signed [CRD_W-1:0] adj_q;
  logic [DW-1:0]           adj_r;
  logic [DW:0]             two_rx, two_ry;
  logic signed [CRD_W-1:0] cx, cy;
  logic                    in_map;
  logic [DW:0]             sum_x, sum_y;
  logic [23:0]             aerr;
  logic [MAG_W-1:0]        mul_a;
  logic [WGT_W-1:0]        mul_b;
  logic [PROD_W:0]         rnd_sum;
  logic [PROD_W-8:0]       rnd;
  logic [OUT_TDATA_W-1:0]  w_val;
  logic                    wr_in_map;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign dx_in = {in_ex[15], in_ex} - {in_sx[15], in_sx};
  assign dy_in = {in_ey[15], in_ey} - {in_sy[15], in_sy};

  assign wr_in_map = (32'(in_wx) < GRID_WIDTH) && (32'(in_wy) < GRID_HEIGHT);
  assign mem_we    = in_accept && (in_op == OP_WRITE) && wr_in_map;
  assign mem_waddr = AW'(AW'(in_wy) * AW'(GRID_WIDTH)) + AW'(in_wx);

  always_comb begin
    cnt_ext = CW'(smp_cnt_q);
    if (cnt_ext < CW'(2)) begin
      n_sel = NW'(2);
    end else if (cnt_ext > CW'(MAX_SAMPLES)) begin
      n_sel = NW'(MAX_SAMPLES);
    end else begin
      n_sel = NW'(cnt_ext);
    end
  end

  // floor-division fixup of the unsigned quotient for a negative delta
  always_comb begin
    adj_neg = (state_q == ST_DIV_X) ? dx_q[16] : dy_q[16];
    if (!adj_neg) begin
      adj_q = CRD_W'(div_quot);
      adj_r = div_rem;
    end else if (div_rem == '0) begin
      adj_q = -CRD_W'(div_quot);
      adj_r = '0;
    end else begin
      adj_q = -CRD_W'(div_quot) - CRD_W'(1);
      adj_r = den_q - div_rem;
    end
  end

  always_comb begin
    mag_src      = (state_q == ST_IDLE) ? dx_in : dy_q;
    div_dividend = mag_src[16] ? DIVD_W'(-mag_src) : DIVD_W'(mag_src);
    div_divisor  = (state_q == ST_IDLE) ? {n_sel - NW'(1), 4'b0000} : den_q;
    div_start    = (in_accept && (in_op == OP_CHECK)) ||
                   ((state_q == ST_DIV_X) && div_done);
  end

  // rounding to the nearest cell, halves away from zero
  always_comb begin
    two_rx = {rx_q, 1'b0};
    two_ry = {ry_q, 1'b0};
    cx = qx_q + CRD_W'(qx_q[CRD_W-1] ? (two_rx > {1'b0, den_q})
                                      : (two_rx >= {1'b0, den_q}));
    cy = qy_q + CRD_W'(qy_q[CRD_W-1] ? (two_ry > {1'b0, den_q})
                                      : (two_ry >= {1'b0, den_q}));
    in_map = !cx[CRD_W-1] && !cy[CRD_W-1] &&
             (cx < $signed(CRD_W'(GRID_WIDTH))) &&
             (cy < $signed(CRD_W'(GRID_HEIGHT)));
    mem_raddr = AW'(AW'(cy[YW-1:0]) * AW'(GRID_WIDTH)) + AW'(cx[XW-1:0]);
    sum_x = {1'b0, rx_q} + {1'b0, rdx_q};
    sum_y = {1'b0, ry_q} + {1'b0, rdy_q};
  end

  // weighting: one shared multiplier on magnitudes
  always_comb begin
    aerr = err_q[23] ? 24'(-err_q) : 24'(err_q);
    if (aerr > {1'b0, half_lane_q}) begin
      mul_a = MAG_W'(aerr);
      mul_b = other_wgt_q;
    end else begin
      mul_a = MAG_W'(aerr) + MAG_W'(pad_off_q);
      mul_b = pad_wgt_q;
    end
    rnd_sum = {1'b0, prod_q} + (PROD_W + 1)'(128);
    rnd     = rnd_sum[PROD_W:8];
    if (!neg_q) begin
      w_val = (rnd > (PROD_W - 7)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : rnd[31:0];
    end else begin
      w_val = (rnd > (PROD_W - 7)'(32'h8000_0000)) ? 32'h8000_0000 : -rnd[31:0];
    end
  end

  // ---------------------------------------------------------- sequencer
  always_comb begin
    state_d    = state_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    err_d      = err_q;
    nm1_d      = nm1_q;
    idx_d      = idx_q;
    den_d      = den_q;
    qx_d       = qx_q;
    qy_d       = qy_q;
    rx_d       = rx_q;
    ry_d       = ry_q;
    qdx_d      = qdx_q;
    qdy_d      = qdy_q;
    rdx_d      = rdx_q;
    rdy_d      = rdy_q;
    blk_d      = blk_q;
    pad_d      = pad_q;
    rd_pend_d  = 1'b0;
    cls_d      = cls_q;
    neg_d      = neg_q;
    prod_d     = prod_q;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    out_vld_d  = out_vld_q && !m_axis_tready;

    // previous map read lands in the cycle after its address
    if (rd_pend_q) begin
      if (rd_data_q == KIND_BLOCKED) blk_d = 1'b1;
      if (rd_data_q == KIND_PADDING) pad_d = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (in_op == OP_CHECK)) begin
          dx_d    = dx_in;
          dy_d    = dy_in;
          err_d   = in_err;
          nm1_d   = n_sel - NW'(1);
          den_d   = {n_sel - NW'(1), 4'b0000};
          qx_d    = CRD_W'(in_sx >>> 4);
          qy_d    = CRD_W'(in_sy >>> 4);
          rx_d    = DW'(DW'(in_sx[3:0]) * DW'(n_sel - NW'(1)));
          ry_d    = DW'(DW'(in_sy[3:0]) * DW'(n_sel - NW'(1)));
          blk_d   = 1'b0;
          pad_d   = 1'b0;
          state_d = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (div_done) begin
          qdx_d   = adj_q;
          rdx_d   = adj_r;
          state_d = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_done) begin
          qdy_d   = adj_q;
          rdy_d   = adj_r;
          idx_d   = '0;
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        rd_pend_d = in_map;
        if (!in_map) blk_d = 1'b1;
        if (sum_x >= {1'b0, den_q}) begin
          rx_d = DW'(sum_x - {1'b0, den_q});
          qx_d = qx_q + qdx_q + CRD_W'(1);
        end else begin
          rx_d = DW'(sum_x);
          qx_d = qx_q + qdx_q;
        end
        if (sum_y >= {1'b0, den_q}) begin
          ry_d = DW'(sum_y - {1'b0, den_q});
          qy_d = qy_q + qdy_q + CRD_W'(1);
        end else begin
          ry_d = DW'(sum_y);
          qy_d = qy_q + qdy_q;
        end
        idx_d = idx_q + NW'(1);
        if (idx_q == nm1_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        priority if (blk_q) begin
          cls_d = CLS_BLOCKED;
        end else if (aerr > {1'b0, half_lane_q}) begin
          cls_d = CLS_OTHER;
        end else if (pad_q) begin
          cls_d = CLS_PADDING;
        end else begin
          cls_d = CLS_PLAIN;
        end
        neg_d   = (cls_d == CLS_OTHER) && err_q[23];
        prod_d  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_user_d = {cls_q, cls_q == CLS_BLOCKED};
          unique case (cls_q)
            CLS_BLOCKED: out_data_d = '0;
            CLS_PLAIN:   out_data_d = OUT_TDATA_W'(err_q);
            default:     out_data_d = w_val;
          endcase
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    err_q      <= err_d;
    nm1_q      <= nm1_d;
    idx_q      <= idx_d;
    den_q      <= den_d;
    qx_q       <= qx_d;
    qy_q       <= qy_d;
    rx_q       <= rx_d;
    ry_q       <= ry_d;
    qdx_q      <= qdx_d;
    qdy_q      <= qdy_d;
    rdx_q      <= rdx_d;
    rdy_q      <= rdy_d;
    blk_q      <= blk_d;
    pad_q      <= pad_d;
    cls_q      <= cls_d;
    neg_q      <= neg_d;
    prod_q     <= prod_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // ----------------------------------------------------------- assertions
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_X) || (state_q == ST_DIV_Y))
    else $error("divider finished outside a divide state");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (rx_q < den_q) && (ry_q < den_q))
    else $error("sample remainder out of range");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result raised outside output state");

  a_no_read_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(state_q == ST_SWEEP))
    else $error("map read issued outside sweep");

endmodule
